// ===== hw/rtl/dual_stepper_solenoid_sequencer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual stepper and solenoid sequencer
// Shared property wrappers; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef DUAL_STEPPER_SOLENOID_SEQUENCER_TOP_MACROS_SVH
`define DUAL_STEPPER_SOLENOID_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Types, codes and helper functions shared by the sequencer modules.
// ----------------------------------------------------------------------------
package dss_pkg;

	// Width of the tick count registers and of the register index.
	localparam int TICK_W    = 7;
	localparam int CFG_IDX_W = 3;

	// Item codes.
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_FIRE  = 2'd2,
		ACT_CLEAR = 2'd3
	} act_t;

	// Power state of a motor, also used for the hammer.
	typedef enum logic [1:0] {
		PWR_IDLE = 2'd0,
		PWR_ON   = 2'd1,
		PWR_COOL = 2'd2
	} pwr_t;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_ON    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_OFF   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHEET_ON   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHEET_OFF  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HAMMER_ON  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HAMMER_OFF = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_MODE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SHEET_MODE = 3'd7;

	// Register reset values.
	localparam logic [TICK_W-1:0] RST_HEAD_ON    = 7'd3;
	localparam logic [TICK_W-1:0] RST_HEAD_OFF   = 7'd0;
	localparam logic [TICK_W-1:0] RST_SHEET_ON   = 7'd2;
	localparam logic [TICK_W-1:0] RST_SHEET_OFF  = 7'd0;
	localparam logic [TICK_W-1:0] RST_HAMMER_ON  = 7'd7;
	localparam logic [TICK_W-1:0] RST_HAMMER_OFF = 7'd10;
	localparam logic              RST_HEAD_MODE  = 1'b1;
	localparam logic              RST_SHEET_MODE = 1'b1;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [TICK_W-1:0] head_on;
		logic [TICK_W-1:0] head_off;
		logic [TICK_W-1:0] sheet_on;
		logic [TICK_W-1:0] sheet_off;
		logic [TICK_W-1:0] hammer_on;
		logic [TICK_W-1:0] hammer_off;
		logic              head_mode;
		logic              sheet_mode;
	} cfg_t;

	// Step event of a motor: fire marks a step, up gives its direction.
	typedef struct packed {
		logic fire;
		logic up;
	} step_t;

	// Coil bits for a phase: one coil, or the phase coil and the next one.
	function automatic logic [3:0] coil_pattern(input logic [1:0] phase, input logic mode);
		logic [3:0] pat;
		if (!mode) begin
			pat = 4'b0001 << phase;
		end else if (phase == 2'd3) begin
			pat = 4'b1001;
		end else begin
			pat = 4'b0011 << phase;
		end
		return pat;
	endfunction

endpackage

// ===== hw/rtl/dual_stepper_solenoid_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// dual_stepper_solenoid_sequencer_top
// Two four-coil steppers and a hammer solenoid, advanced one item at a time.
// ----------------------------------------------------------------------------
// Path: an item passes the input register, then the state registers that
// also serve as the result register.
// Throughput: one item per cycle unless the result side stalls; the state update is one pass of logic.
// Reset: registers take their default values and all state clears at once.
module dual_stepper_solenoid_sequencer_top #(
	parameter int COUNT_BITS  = 16,
	parameter int ELAPSED_CAP = 100
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [1:0]                    action,
	input  logic                          motor_sel,
	input  logic signed [15:0]            step_count,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [3:0]                    head_coils,
	output logic [3:0]                    sheet_coils,
	output logic                          hammer_drive,
	output logic signed [15:0]            head_position,
	output logic signed [15:0]            head_left,
	output logic signed [15:0]            sheet_left,
	output logic [1:0]                    head_mode,
	output logic [1:0]                    sheet_mode,
	output logic [1:0]                    hammer_mode,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dss_pkg::TICK_W-1:0]    cfg_data
);
	import dss_pkg::*;

	localparam int EL_W = $clog2(ELAPSED_CAP + 1);
	localparam int WIDE = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
	localparam logic signed [WIDE-1:0] MAX_W =
		{{(WIDE - COUNT_BITS + 1){1'b0}}, {(COUNT_BITS - 1){1'b1}}};
	localparam logic signed [WIDE-1:0] MIN_W = ~MAX_W;
	localparam logic signed [COUNT_BITS-1:0] CNT_MAX = MAX_W[COUNT_BITS-1:0];
	localparam logic signed [COUNT_BITS-1:0] CNT_MIN = MIN_W[COUNT_BITS-1:0];

	cfg_t cfg;

	// Input register.
	logic                valid_s1;
	logic [1:0]          action_s1;
	logic                motor_sel_s1;
	logic signed [15:0]  step_count_s1;

	// State registers, which also hold the result.
	logic                         result_valid_q;
	logic [1:0]                   head_phase_q, sheet_phase_q;
	pwr_t                         head_power_q, sheet_power_q, hammer_state_q;
	logic [EL_W-1:0]              head_elapsed_q, sheet_elapsed_q, hammer_elapsed_q;
	logic signed [COUNT_BITS-1:0] head_pending_q, sheet_pending_q, head_pos_q;
	logic [3:0]                   head_latch_q, sheet_latch_q;

	// Next-state values.
	logic [1:0]                   head_phase_d, sheet_phase_d;
	pwr_t                         head_power_d, sheet_power_d, hammer_state_d;
	logic [EL_W-1:0]              head_elapsed_d, sheet_elapsed_d, hammer_elapsed_d;
	logic signed [COUNT_BITS-1:0] head_pending_d, sheet_pending_d, head_pos_d;
	logic [3:0]                   head_latch_d, sheet_latch_d;
	step_t                        head_step, sheet_step;

	logic                         advance;
	logic                         update;
	act_t                         act;
	logic                         is_tick, is_load, is_fire, is_clear;
	logic                         hammer_on;
	logic signed [WIDE-1:0]       cnt_w;
	logic signed [COUNT_BITS-1:0] cnt_sat;
	logic signed [WIDE-1:0]       pos_w, head_left_w, sheet_left_w;

	dss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake: the stage moves when the result slot is empty or being taken.
	assign advance    = !result_valid_q || result_ready;
	assign item_ready = !valid_s1 || advance;
	assign update     = valid_s1 && advance;

	// Item decode.
	assign act      = act_t'(action_s1);
	assign is_tick  = valid_s1 && (act == ACT_TICK);
	assign is_load  = valid_s1 && (act == ACT_LOAD);
	assign is_fire  = valid_s1 && (act == ACT_FIRE);
	assign is_clear = valid_s1 && (act == ACT_CLEAR);

	// Loaded count saturated to the counter range.
	always_comb begin
		cnt_w = WIDE'(step_count_s1);
		if (cnt_w > MAX_W) begin
			cnt_sat = CNT_MAX;
		end else if (cnt_w < MIN_W) begin
			cnt_sat = CNT_MIN;
		end else begin
			cnt_sat = cnt_w[COUNT_BITS-1:0];
		end
	end

	dss_hammer #(
		.ELAPSED_CAP (ELAPSED_CAP),
		.EL_W        (EL_W)
	) u_hammer (
		.tick      (is_tick),
		.fire      (is_fire),
		.on_ticks  (cfg.hammer_on),
		.off_ticks (cfg.hammer_off),
		.state_q   (hammer_state_q),
		.elapsed_q (hammer_elapsed_q),
		.state_d   (hammer_state_d),
		.elapsed_d (hammer_elapsed_d),
		.energized (hammer_on)
	);

	dss_motor #(
		.COUNT_BITS  (COUNT_BITS),
		.ELAPSED_CAP (ELAPSED_CAP),
		.EL_W        (EL_W)
	) u_head (
		.tick       (is_tick),
		.load       (is_load && !motor_sel_s1),
		.clear      (is_clear && !motor_sel_s1),
		.load_value (cnt_sat),
		.on_ticks   (cfg.head_on),
		.off_ticks  (cfg.head_off),
		.drive_mode (cfg.head_mode),
		.hammer_on  (hammer_on),
		.phase_q    (head_phase_q),
		.power_q    (head_power_q),
		.elapsed_q  (head_elapsed_q),
		.pending_q  (head_pending_q),
		.latch_q    (head_latch_q),
		.phase_d    (head_phase_d),
		.power_d    (head_power_d),
		.elapsed_d  (head_elapsed_d),
		.pending_d  (head_pending_d),
		.latch_d    (head_latch_d),
		.step       (head_step)
	);

	dss_motor #(
		.COUNT_BITS  (COUNT_BITS),
		.ELAPSED_CAP (ELAPSED_CAP),
		.EL_W        (EL_W)
	) u_sheet (
		.tick       (is_tick),
		.load       (is_load && motor_sel_s1),
		.clear      (is_clear && motor_sel_s1),
		.load_value (cnt_sat),
		.on_ticks   (cfg.sheet_on),
		.off_ticks  (cfg.sheet_off),
		.drive_mode (cfg.sheet_mode),
		.hammer_on  (hammer_on),
		.phase_q    (sheet_phase_q),
		.power_q    (sheet_power_q),
		.elapsed_q  (sheet_elapsed_q),
		.pending_q  (sheet_pending_q),
		.latch_q    (sheet_latch_q),
		.phase_d    (sheet_phase_d),
		.power_d    (sheet_power_d),
		.elapsed_d  (sheet_elapsed_d),
		.pending_d  (sheet_pending_d),
		.latch_d    (sheet_latch_d),
		.step       (sheet_step)
	);

	// Head position follows head steps, saturates at the counter range and clears with a head clear.
	always_comb begin
		head_pos_d = head_pos_q;
		if (is_clear && !motor_sel_s1) begin
			head_pos_d = '0;
		end else if (head_step.fire) begin
			if (head_step.up) begin
				head_pos_d = (head_pos_q == CNT_MAX) ? head_pos_q
					: head_pos_q + COUNT_BITS'(1);
			end else begin
				head_pos_d = (head_pos_q == CNT_MIN) ? head_pos_q
					: head_pos_q - COUNT_BITS'(1);
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			action_s1     <= action;
			motor_sel_s1  <= motor_sel;
			step_count_s1 <= step_count;
		end
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			result_valid_q   <= 1'b0;
			head_phase_q     <= '0;
			sheet_phase_q    <= '0;
			head_power_q     <= PWR_IDLE;
			sheet_power_q    <= PWR_IDLE;
			hammer_state_q   <= PWR_IDLE;
			head_elapsed_q   <= '0;
			sheet_elapsed_q  <= '0;
			hammer_elapsed_q <= '0;
			head_pending_q   <= '0;
			sheet_pending_q  <= '0;
			head_pos_q       <= '0;
			head_latch_q     <= '0;
			sheet_latch_q    <= '0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
			if (update) begin
				head_phase_q     <= head_phase_d;
				sheet_phase_q    <= sheet_phase_d;
				head_power_q     <= head_power_d;
				sheet_power_q    <= sheet_power_d;
				hammer_state_q   <= hammer_state_d;
				head_elapsed_q   <= head_elapsed_d;
				sheet_elapsed_q  <= sheet_elapsed_d;
				hammer_elapsed_q <= hammer_elapsed_d;
				head_pending_q   <= head_pending_d;
				sheet_pending_q  <= sheet_pending_d;
				head_pos_q       <= head_pos_d;
				head_latch_q     <= head_latch_d;
				sheet_latch_q    <= sheet_latch_d;
			end
		end
	end

	// Result fields, counters shown as their low sixteen bits.
	assign pos_w        = WIDE'(head_pos_q);
	assign head_left_w  = WIDE'(head_pending_q);
	assign sheet_left_w = WIDE'(sheet_pending_q);

	assign result_valid  = result_valid_q;
	assign head_coils    = head_latch_q;
	assign sheet_coils   = sheet_latch_q;
	assign hammer_drive  = (hammer_state_q == PWR_ON);
	assign head_position = pos_w[15:0];
	assign head_left     = head_left_w[15:0];
	assign sheet_left    = sheet_left_w[15:0];
	assign head_mode     = head_power_q;
	assign sheet_mode    = sheet_power_q;
	assign hammer_mode   = hammer_state_q;

endmodule

// ===== hw/rtl/dss_cfg.sv =====
// ----------------------------------------------------------------------------
// dss_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module dss_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dss_pkg::TICK_W-1:0]     cfg_data,
	output dss_pkg::cfg_t                  cfg
);
	import dss_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// One register is updated per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_on    <= RST_HEAD_ON;
			cfg_q.head_off   <= RST_HEAD_OFF;
			cfg_q.sheet_on   <= RST_SHEET_ON;
			cfg_q.sheet_off  <= RST_SHEET_OFF;
			cfg_q.hammer_on  <= RST_HAMMER_ON;
			cfg_q.hammer_off <= RST_HAMMER_OFF;
			cfg_q.head_mode  <= RST_HEAD_MODE;
			cfg_q.sheet_mode <= RST_SHEET_MODE;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HEAD_ON:    cfg_q.head_on    <= cfg_data;
				CFG_HEAD_OFF:   cfg_q.head_off   <= cfg_data;
				CFG_SHEET_ON:   cfg_q.sheet_on   <= cfg_data;
				CFG_SHEET_OFF:  cfg_q.sheet_off  <= cfg_data;
				CFG_HAMMER_ON:  cfg_q.hammer_on  <= cfg_data;
				CFG_HAMMER_OFF: cfg_q.hammer_off <= cfg_data;
				CFG_HEAD_MODE:  cfg_q.head_mode  <= cfg_data[0];
				CFG_SHEET_MODE: cfg_q.sheet_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/dss_motor.sv =====
// ----------------------------------------------------------------------------
// dss_motor
// Next-state logic of one stepper: power sequencing, phase, pending count
// and coil latch, plus the load and clear commands.
// ----------------------------------------------------------------------------
module dss_motor #(
	parameter int COUNT_BITS  = 16,
	parameter int ELAPSED_CAP = 100,
	parameter int EL_W        = $clog2(ELAPSED_CAP + 1)
) (
	input  logic                         tick,
	input  logic                         load,
	input  logic                         clear,
	input  logic signed [COUNT_BITS-1:0] load_value,
	input  logic [dss_pkg::TICK_W-1:0]   on_ticks,
	input  logic [dss_pkg::TICK_W-1:0]   off_ticks,
	input  logic                         drive_mode,
	input  logic                         hammer_on,
	input  logic [1:0]                   phase_q,
	input  dss_pkg::pwr_t                power_q,
	input  logic [EL_W-1:0]              elapsed_q,
	input  logic signed [COUNT_BITS-1:0] pending_q,
	input  logic [3:0]                   latch_q,
	output logic [1:0]                   phase_d,
	output dss_pkg::pwr_t                power_d,
	output logic [EL_W-1:0]              elapsed_d,
	output logic signed [COUNT_BITS-1:0] pending_d,
	output logic [3:0]                   latch_d,
	output dss_pkg::step_t               step
);
	import dss_pkg::*;

	localparam int CMP_W = (EL_W > TICK_W) ? EL_W : TICK_W;
	localparam logic [EL_W-1:0] CAP = EL_W'(ELAPSED_CAP);

	logic             pend_nz;
	logic             pend_pos;
	logic [CMP_W-1:0] el_c;
	logic [CMP_W-1:0] on_c;
	logic [CMP_W-1:0] off_c;
	logic             do_step;
	logic             go_cool;
	logic             go_idle;
	logic             clr_latch;
	logic             hold;
	logic [EL_W-1:0]  el_base;

	assign pend_nz  = |pending_q;
	assign pend_pos = pend_nz && !pending_q[COUNT_BITS-1];
	assign el_c     = CMP_W'(elapsed_q);
	assign on_c     = CMP_W'(on_ticks);
	assign off_c    = CMP_W'(off_ticks);

	// Next power state and the action taken on this tick.
	always_comb begin
		power_d   = power_q;
		do_step   = 1'b0;
		go_cool   = 1'b0;
		go_idle   = 1'b0;
		clr_latch = 1'b0;
		hold      = 1'b0;
		if (tick) begin
			case (power_q)
				PWR_ON: begin
					if (elapsed_q == '0) begin
						// A fresh step waits while the hammer is energized.
						if (!hammer_on) begin
							do_step = 1'b1;
						end else begin
							hold = 1'b1;
						end
					end else if (on_c <= el_c) begin
						if (off_ticks != '0) begin
							go_cool = 1'b1;
						end else if (pend_nz) begin
							do_step = 1'b1;
						end else begin
							go_idle = 1'b1;
						end
					end
				end
				PWR_COOL: begin
					if (off_c <= el_c) begin
						if (pend_nz) begin
							do_step = 1'b1;
						end else begin
							go_idle = 1'b1;
						end
					end
				end
				PWR_IDLE: begin
					if (pend_nz) begin
						do_step = 1'b1;
					end else begin
						clr_latch = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (do_step) begin
				power_d = PWR_ON;
			end else if (go_cool) begin
				power_d = PWR_COOL;
			end else if (go_idle) begin
				power_d = PWR_IDLE;
			end
		end
	end

	// Phase, pending count, coils and elapsed counter.
	always_comb begin
		step.fire = do_step;
		step.up   = pend_pos;

		phase_d = phase_q;
		if (do_step) begin
			phase_d = pend_pos ? phase_q + 2'd1 : phase_q - 2'd1;
		end

		pending_d = pending_q;
		if (clear) begin
			pending_d = '0;
		end else if (load) begin
			pending_d = load_value;
		end else if (do_step) begin
			pending_d = pend_pos ? pending_q - COUNT_BITS'(1) : pending_q + COUNT_BITS'(1);
		end

		latch_d = latch_q;
		if (do_step) begin
			latch_d = coil_pattern(phase_d, drive_mode);
		end else if (go_cool || go_idle || clr_latch) begin
			latch_d = '0;
		end

		el_base = (do_step || go_cool || go_idle) ? '0 : elapsed_q;
		if (!tick || hold) begin
			elapsed_d = el_base;
		end else if (el_base < CAP) begin
			elapsed_d = el_base + EL_W'(1);
		end else begin
			elapsed_d = el_base;
		end
	end

endmodule

// ===== hw/rtl/dss_hammer.sv =====
// ----------------------------------------------------------------------------
// dss_hammer
// Next-state logic of the hammer solenoid: fire, on-time and recovery.
// ----------------------------------------------------------------------------
module dss_hammer #(
	parameter int ELAPSED_CAP = 100,
	parameter int EL_W        = $clog2(ELAPSED_CAP + 1)
) (
	input  logic                       tick,
	input  logic                       fire,
	input  logic [dss_pkg::TICK_W-1:0] on_ticks,
	input  logic [dss_pkg::TICK_W-1:0] off_ticks,
	input  dss_pkg::pwr_t              state_q,
	input  logic [EL_W-1:0]            elapsed_q,
	output dss_pkg::pwr_t              state_d,
	output logic [EL_W-1:0]            elapsed_d,
	output logic                       energized
);
	import dss_pkg::*;

	localparam int CMP_W = (EL_W > TICK_W) ? EL_W : TICK_W;
	localparam logic [EL_W-1:0] CAP = EL_W'(ELAPSED_CAP);

	logic            restart;
	logic [EL_W-1:0] el_base;

	// Next state; a fire restarts the on-time even when busy.
	always_comb begin
		state_d = state_q;
		restart = 1'b0;
		if (fire) begin
			state_d = PWR_ON;
			restart = 1'b1;
		end else if (tick) begin
			case (state_q)
				PWR_IDLE: begin
				end
				PWR_ON: begin
					if (CMP_W'(elapsed_q) >= CMP_W'(on_ticks)) begin
						state_d = PWR_COOL;
						restart = 1'b1;
					end
				end
				default: begin
					if (CMP_W'(elapsed_q) >= CMP_W'(off_ticks)) begin
						state_d = PWR_IDLE;
						restart = 1'b1;
					end
				end
			endcase
		end
	end

	// Elapsed counter and drive.
	always_comb begin
		el_base = restart ? '0 : elapsed_q;
		if (tick && el_base < CAP) begin
			elapsed_d = el_base + EL_W'(1);
		end else begin
			elapsed_d = el_base;
		end
		energized = (state_d == PWR_ON);
	end

endmodule

// ===== hw/rtl/dss_checker.sv =====
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks on the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_stepper_solenoid_sequencer_top_macros.svh"

module dss_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [3:0]                    head_coils,
	input logic [3:0]                    sheet_coils,
	input logic                          hammer_drive,
	input logic signed [15:0]            head_position,
	input logic signed [15:0]            head_left,
	input logic [1:0]                    head_mode,
	input logic [1:0]                    sheet_mode,
	input logic [1:0]                    hammer_mode
);
	import dss_pkg::*;

	// A stalled result stays offered with the same head state.
	`DSS_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(head_position) && $stable(head_left), "stalled result changed")

	// The input side only stalls while a result is waiting.
	`DSS_ASSERT_IMP(a_stall_cause, !item_ready, result_valid && !result_ready, "input stalled without a waiting result")

	// Hammer drive agrees with the hammer state.
	`DSS_ASSERT_IMP(a_hammer_drive, result_valid, hammer_drive == (hammer_mode == PWR_ON), "hammer drive disagrees with state")

	// An idle motor has its coils off.
	`DSS_ASSERT_IMP(a_idle_coils, result_valid && (head_mode == PWR_IDLE || sheet_mode == PWR_IDLE), (head_mode != PWR_IDLE || head_coils == 4'd0) && (sheet_mode != PWR_IDLE || sheet_coils == 4'd0), "idle motor has coils energized")

endmodule

bind dual_stepper_solenoid_sequencer_top dss_checker u_dss_checker (.*);

// ===== tb/sequencer_checker.sv =====
// ----------------------------------------------------------------------------
// sequencer_checker
// Watches the item, result and register channels of the sequencer. It keeps
// its own copy of the motor, hammer and register state, works out the outputs
// that each accepted item must produce, and compares every result transfer
// field by field against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module sequencer_checker
	import dss_pkg::*;
#(
	parameter int ELAPSED_CAP = 100
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  logic [1:0]           action,
	input  logic                 motor_sel,
	input  logic signed [15:0]   step_count,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  logic [3:0]           head_coils,
	input  logic [3:0]           sheet_coils,
	input  logic                 hammer_drive,
	input  logic signed [15:0]   head_position,
	input  logic signed [15:0]   head_left,
	input  logic signed [15:0]   sheet_left,
	input  logic [1:0]           head_mode,
	input  logic [1:0]           sheet_mode,
	input  logic [1:0]           hammer_mode,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	output int                   mismatches,
	output logic                 results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_MAX = 32767;
	localparam int POS_MIN = -32768;

	// One result as the block shows it after an item.
	typedef struct packed {
		logic [3:0]         head_coils;
		logic [3:0]         sheet_coils;
		logic               hammer_drive;
		logic signed [15:0] head_position;
		logic signed [15:0] head_left;
		logic signed [15:0] sheet_left;
		pwr_t               head_mode;
		pwr_t               sheet_mode;
		pwr_t               hammer_mode;
	} seq_outputs_t;

	// Everything one stepper carries from tick to tick.
	typedef struct packed {
		logic [1:0]         phase;
		pwr_t               power;
		logic [TICK_W-1:0]  elapsed;
		logic signed [15:0] pending;
		logic [3:0]         coils;
	} motor_t;

	cfg_t               settings;
	motor_t             head;
	motor_t             sheet;
	pwr_t               hammer;
	logic [TICK_W-1:0]  hammer_elapsed;
	logic signed [15:0] head_pos;
	seq_outputs_t       expected_outputs[$];
	int                 mismatch_count = 0;

	assign mismatches = mismatch_count;

	// Prints one line per mismatch, up to a cap, and counts them all.
	task automatic report_mismatch(input string what);
		if (mismatch_count < 50)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// One tick of a stepper: dwell, cooldown, or a step toward zero pending.
	function automatic motor_t advance_motor(input motor_t m, input logic [TICK_W-1:0] on_t,
		input logic [TICK_W-1:0] off_t, input logic drive, input logic hammer_busy,
		output int moved);
		motor_t n;
		logic   hold;
		logic   stepping;
		n = m;
		hold = 1'b0;
		stepping = 1'b0;
		moved = 0;
		case (m.power)
			PWR_ON: begin
				if (m.elapsed == '0) begin
					if (!hammer_busy)
						stepping = 1'b1;
					else
						hold = 1'b1;
				end else if (on_t <= m.elapsed) begin
					if (off_t != '0) begin
						n.coils = '0;
						n.power = PWR_COOL;
						n.elapsed = '0;
					end else if (m.pending != '0) begin
						stepping = 1'b1;
					end else begin
						n.power = PWR_IDLE;
						n.elapsed = '0;
						n.coils = '0;
					end
				end
			end
			PWR_COOL: begin
				if (off_t <= m.elapsed) begin
					if (m.pending == '0) begin
						n.power = PWR_IDLE;
						n.elapsed = '0;
						n.coils = '0;
					end else begin
						stepping = 1'b1;
					end
				end
			end
			PWR_IDLE: begin
				if (m.pending != '0)
					stepping = 1'b1;
				else
					n.coils = '0;
			end
			default: ;
		endcase

		// A step moves one phase: forward while pending is positive, else back.
		if (stepping) begin
			n.power = PWR_ON;
			n.elapsed = '0;
			if (!m.pending[15] && m.pending != '0) begin
				n.phase = m.phase + 2'd1;
				n.pending = m.pending - 16'sd1;
				moved = 1;
			end else begin
				n.phase = m.phase - 2'd1;
				n.pending = m.pending + 16'sd1;
				moved = -1;
			end
			if (!drive)
				n.coils = 4'b0001 << n.phase;
			else
				n.coils = (4'b0011 << n.phase) | ((n.phase == 2'd3) ? 4'b0001 : 4'b0000);
		end

		if (!hold && n.elapsed < ELAPSED_CAP)
			n.elapsed = n.elapsed + 1'b1;
		return n;
	endfunction

	// Updates the predicted state for one accepted item.
	function void apply_item(input act_t act, input logic sel,
		input logic signed [15:0] count);
		int moved;
		int pos;
		case (act)
			ACT_TICK: begin
				// The hammer advances first; the motors see its new state.
				case (hammer)
					PWR_IDLE: ;
					PWR_ON: begin
						if (hammer_elapsed >= settings.hammer_on) begin
							hammer = PWR_COOL;
							hammer_elapsed = '0;
						end
					end
					default: begin
						if (hammer_elapsed >= settings.hammer_off) begin
							hammer = PWR_IDLE;
							hammer_elapsed = '0;
						end
					end
				endcase
				if (hammer_elapsed < ELAPSED_CAP)
					hammer_elapsed = hammer_elapsed + 1'b1;

				head = advance_motor(head, settings.head_on, settings.head_off,
					settings.head_mode, hammer == PWR_ON, moved);
				pos = head_pos + moved;
				if (pos > POS_MAX)
					pos = POS_MAX;
				else if (pos < POS_MIN)
					pos = POS_MIN;
				head_pos = pos;
				sheet = advance_motor(sheet, settings.sheet_on, settings.sheet_off,
					settings.sheet_mode, hammer == PWR_ON, moved);
			end
			ACT_LOAD: begin
				if (sel)
					sheet.pending = count;
				else
					head.pending = count;
			end
			ACT_FIRE: begin
				hammer = PWR_ON;
				hammer_elapsed = '0;
			end
			default: begin
				if (sel) begin
					sheet.pending = '0;
				end else begin
					head.pending = '0;
					head_pos = '0;
				end
			end
		endcase
	endfunction

	// Results are checked before the new item is predicted in the same cycle.
	always @(posedge clk or negedge arst_n) begin
		seq_outputs_t want;
		if (!arst_n) begin
			settings.head_on = RST_HEAD_ON;
			settings.head_off = RST_HEAD_OFF;
			settings.sheet_on = RST_SHEET_ON;
			settings.sheet_off = RST_SHEET_OFF;
			settings.hammer_on = RST_HAMMER_ON;
			settings.hammer_off = RST_HAMMER_OFF;
			settings.head_mode = RST_HEAD_MODE;
			settings.sheet_mode = RST_SHEET_MODE;
			head = '{phase: 2'd0, power: PWR_IDLE, elapsed: '0, pending: '0, coils: '0};
			sheet = head;
			hammer = PWR_IDLE;
			hammer_elapsed = '0;
			head_pos = '0;
			expected_outputs.delete();
			results_owed <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_outputs.size() == 0) begin
					report_mismatch("result transfer with no item outstanding");
				end else begin
					want = expected_outputs.pop_front();
					check_field("head_coils", head_coils, want.head_coils);
					check_field("sheet_coils", sheet_coils, want.sheet_coils);
					check_field("hammer_drive", hammer_drive, want.hammer_drive);
					check_field("head_position", head_position, want.head_position);
					check_field("head_left", head_left, want.head_left);
					check_field("sheet_left", sheet_left, want.sheet_left);
					check_field("head_mode", head_mode, want.head_mode);
					check_field("sheet_mode", sheet_mode, want.sheet_mode);
					check_field("hammer_mode", hammer_mode, want.hammer_mode);
				end
			end

			// Register writes must only happen while the block is idle; the checker does not enforce this.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HEAD_ON:    settings.head_on = cfg_data;
					CFG_HEAD_OFF:   settings.head_off = cfg_data;
					CFG_SHEET_ON:   settings.sheet_on = cfg_data;
					CFG_SHEET_OFF:  settings.sheet_off = cfg_data;
					CFG_HAMMER_ON:  settings.hammer_on = cfg_data;
					CFG_HAMMER_OFF: settings.hammer_off = cfg_data;
					CFG_HEAD_MODE:  settings.head_mode = cfg_data[0];
					CFG_SHEET_MODE: settings.sheet_mode = cfg_data[0];
					default: ;
				endcase
			end

			if (item_valid && item_ready) begin
				apply_item(act_t'(action), motor_sel, step_count);
				want.head_coils = head.coils;
				want.sheet_coils = sheet.coils;
				want.hammer_drive = (hammer == PWR_ON);
				want.head_position = head_pos;
				want.head_left = head.pending;
				want.sheet_left = sheet.pending;
				want.head_mode = head.power;
				want.sheet_mode = sheet.power;
				want.hammer_mode = hammer;
				expected_outputs.push_back(want);
			end

			results_owed <= (expected_outputs.size() != 0);
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the dual stepper and solenoid sequencer with a short directed run
// and random items under several register settings, with random gaps on the
// item side and random stalls on the result side. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dss_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	logic [1:0]           action = ACT_TICK;
	logic                 motor_sel = 1'b0;
	logic signed [15:0]   step_count = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic [3:0]           head_coils;
	logic [3:0]           sheet_coils;
	logic                 hammer_drive;
	logic signed [15:0]   head_position;
	logic signed [15:0]   head_left;
	logic signed [15:0]   sheet_left;
	logic [1:0]           head_mode;
	logic [1:0]           sheet_mode;
	logic [1:0]           hammer_mode;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_HEAD_ON;
	logic [TICK_W-1:0]    cfg_data = '0;
	int                   mismatches;
	logic                 results_owed;
	logic                 no_idling = 1'b0;
	int                   cycle_count = 0;

	dual_stepper_solenoid_sequencer_top dut (.*);

	sequencer_checker seq_check (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs or loses a result.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", CYCLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Tick counts: often zero, sometimes anywhere from 0 to 100, usually short.
	function automatic logic [TICK_W-1:0] pick_ticks();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 30)
			return TICK_W'($urandom_range(0, 100));
		return TICK_W'($urandom_range(1, 6));
	endfunction

	// Result side: ready runs broken by stalls of random length.
	initial begin
		int run;
		int stall;
		@(posedge clk);
		forever begin
			if (no_idling) begin
				result_ready <= 1'b1;
				@(posedge clk);
			end else begin
				run = $urandom_range(1, 12);
				stall = pick_gap();
				result_ready <= 1'b1;
				repeat (run) @(posedge clk);
				if (stall > 0) begin
					result_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	// One item transfer, after an optional gap; valid stays high afterwards.
	task automatic send_item(input act_t act, input logic sel, input logic signed [15:0] count);
		int gap;
		gap = no_idling ? 0 : pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		motor_sel <= sel;
		step_count <= count;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	// Stops sending and waits for every outstanding result.
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (results_owed) @(posedge clk);
	endtask

	// Writes all eight registers back to back once the block is idle.
	task automatic apply_settings(input logic [TICK_W-1:0] head_on, head_off, sheet_on,
		sheet_off, hammer_on, hammer_off, input logic head_drive, sheet_drive);
		logic [CFG_IDX_W-1:0] regs [8];
		logic [TICK_W-1:0]    vals [8];
		regs = '{CFG_HEAD_ON, CFG_HEAD_OFF, CFG_SHEET_ON, CFG_SHEET_OFF,
			CFG_HAMMER_ON, CFG_HAMMER_OFF, CFG_HEAD_MODE, CFG_SHEET_MODE};
		vals = '{head_on, head_off, sheet_on, sheet_off, hammer_on, hammer_off,
			{{(TICK_W-1){1'b0}}, head_drive}, {{(TICK_W-1){1'b0}}, sheet_drive}};
		settle();
		cfg_valid <= 1'b1;
		for (int i = 0; i < 8; i++) begin
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Main stimulus and verdict.
	initial begin
		int r;
		logic signed [15:0] count;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset settings: extremes, restarts, clears.
		send_item(ACT_TICK, 1'b0, 16'sd0);
		send_item(ACT_LOAD, 1'b0, 16'sh7FFF);
		send_item(ACT_LOAD, 1'b1, 16'sh8000);
		send_item(ACT_TICK, 1'b1, 16'shFFFF);
		send_item(ACT_FIRE, 1'b0, 16'sd0);
		send_item(ACT_TICK, 1'b0, 16'sd0);
		send_item(ACT_TICK, 1'b0, 16'sd0);
		send_item(ACT_CLEAR, 1'b0, 16'sd0);
		send_item(ACT_CLEAR, 1'b1, 16'sd0);
		send_item(ACT_LOAD, 1'b0, 16'sd3);
		send_item(ACT_LOAD, 1'b1, -16'sd2);
		repeat (6) send_item(ACT_TICK, 1'b0, 16'sd0);
		send_item(ACT_FIRE, 1'b0, 16'sd0);
		send_item(ACT_FIRE, 1'b1, 16'sd0);
		send_item(ACT_TICK, 1'b0, 16'sd0);
		send_item(ACT_LOAD, 1'b0, 16'shAAAA);
		send_item(ACT_LOAD, 1'b1, 16'sh5555);
		send_item(ACT_TICK, 1'b0, 16'sd0);
		send_item(ACT_CLEAR, 1'b0, 16'sd0);
		send_item(ACT_CLEAR, 1'b1, 16'sd0);

		// Random phases, each under its own register settings.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: apply_settings(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0);
				1: apply_settings(7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 1'b1, 1'b1);
				2: apply_settings(7'd1, 7'd2, 7'd4, 7'd8, 7'd16, 7'd5, 1'b1, 1'b0);
				default: apply_settings(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
					pick_ticks(), pick_ticks(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			endcase
			for (int n = 0; n < 250; n++) begin
				if (n % 50 == 0)
					no_idling = ($urandom_range(0, 3) == 0);
				// Mostly ticks, with loads of small counts so motors keep moving.
				r = $urandom_range(0, 99);
				count = 16'($urandom);
				if (r < 68) begin
					send_item(ACT_TICK, 1'($urandom_range(0, 1)), count);
				end else if (r < 82) begin
					if ($urandom_range(0, 4) != 0)
						count = 16'($urandom_range(0, 24) - 12);
					send_item(ACT_LOAD, 1'($urandom_range(0, 1)), count);
				end else if (r < 90) begin
					send_item(ACT_FIRE, 1'($urandom_range(0, 1)), count);
				end else begin
					send_item(ACT_CLEAR, 1'($urandom_range(0, 1)), count);
				end
			end
		end
		no_idling = 1'b0;

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
